// ----- hw/rtl/nvec_pkg.sv -----
// shared constants for the 3d vector normalization block
package nvec_pkg;

  // extra fraction bits carried on the vector length
  localparam int LEN_EXTRA = 14;

  // number of vector components, one lane each
  localparam int NUM_LANES = 3;

endpackage

// ----- hw/rtl/nvec_in_if.sv -----
// input channel: base point, target point and wanted length
interface nvec_in_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] base_x;
  logic signed [W-1:0] base_y;
  logic signed [W-1:0] base_z;
  logic signed [W-1:0] target_x;
  logic signed [W-1:0] target_y;
  logic signed [W-1:0] target_z;
  logic [W-2:0]        scale_length;

  modport source (
    output valid, base_x, base_y, base_z, target_x, target_y, target_z, scale_length,
    input  ready
  );
  modport sink (
    input  valid, base_x, base_y, base_z, target_x, target_y, target_z, scale_length,
    output ready
  );
endinterface

// ----- hw/rtl/nvec_out_if.sv -----
// output channel: scaled direction and zero length flag
interface nvec_out_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;
  logic                zero_length;

  modport source (
    output valid, dir_x, dir_y, dir_z, zero_length,
    input  ready
  );
  modport sink (
    input  valid, dir_x, dir_y, dir_z, zero_length,
    output ready
  );
endinterface

// ----- hw/rtl/nvec_lane.sv -----
// one component lane front end: difference, magnitude, square and length product
module nvec_lane #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                ce,
  input  logic signed [W-1:0] base,
  input  logic signed [W-1:0] target,
  input  logic [W-2:0]        len,
  output logic [2*W+1:0]      sq,
  output logic [2*W-1:0]      prod,
  output logic                neg
);

  logic [W:0]   diff;
  logic [W:0]   mag_c;
  logic [W:0]   mag;
  logic         neg1;
  logic [W-2:0] len1;

  // exact difference in one extra bit
  assign diff  = {target[W-1], target} - {base[W-1], base};
  assign mag_c = diff[W] ? (~diff + {{W{1'b0}}, 1'b1}) : diff;

  // stage 1: magnitude and sign
  always_ff @(posedge clk) begin
    if (ce) begin
      mag  <= mag_c;
      neg1 <= diff[W];
      len1 <= len;
    end
  end

  // stage 2: square for the length, product for the numerator
  always_ff @(posedge clk) begin
    if (ce) begin
      sq   <= (2*W+2)'(mag) * (2*W+2)'(mag);
      prod <= (2*W)'(mag) * (2*W)'(len1);
      neg  <= neg1;
    end
  end

endmodule

// ----- hw/rtl/nvec_sqrt.sv -----
// merge of the lane squares and pipelined integer square root, one bit per stage
module nvec_sqrt import nvec_pkg::*; #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic                       ce,
  input  logic [2*W+1:0]             sq0,
  input  logic [2*W+1:0]             sq1,
  input  logic [2*W+1:0]             sq2,
  output logic [W+1+LEN_EXTRA:0]     root,
  output logic                       zero
);

  localparam int SW  = 2*W + 4;
  localparam int RW  = SW + 2*LEN_EXTRA;
  localparam int EW  = RW / 2;
  localparam int RMW = EW + 3;

  logic [SW-1:0]  sum_c;
  logic [RW-1:0]  rad_m;
  logic           z_m;

  logic [RW-1:0]  rad_q  [EW];
  logic [RMW-1:0] rem_q  [EW];
  logic [EW-1:0]  root_q [EW];
  logic           z_q    [EW];

  assign sum_c = SW'(sq0) + SW'(sq1) + SW'(sq2);

  // merge stage: sum of squares scaled by the extra length bits
  always_ff @(posedge clk) begin
    if (ce) begin
      rad_m <= {sum_c, {(2*LEN_EXTRA){1'b0}}};
      z_m   <= (sum_c == '0);
    end
  end

  for (genvar k = 0; k < EW; k++) begin : g_stage
    logic [RW-1:0]  rad_i;
    logic [RMW-1:0] rem_i;
    logic [EW-1:0]  root_i;
    logic           z_i;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_i  = rad_m;
      assign rem_i  = '0;
      assign root_i = '0;
      assign z_i    = z_m;
    end else begin : g_next
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign z_i    = z_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_i[RMW-3:0], rad_i[RW-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rad_q[k]  <= rad_i << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_i[EW-2:0], ge};
        z_q[k]    <= z_i;
      end
    end
  end

  assign root = root_q[EW-1];
  assign zero = z_q[EW-1];

endmodule

// ----- hw/rtl/nvec_div.sv -----
// one lane divider: restoring division, one quotient bit per stage, then sign
module nvec_div import nvec_pkg::*; #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   ce,
  input  logic [2*W-1:0]         prod,
  input  logic [W+1+LEN_EXTRA:0] dvs,
  input  logic                   neg,
  output logic signed [W-1:0]    dir
);

  localparam int EW = W + 2 + LEN_EXTRA;
  localparam int NW = 2*W + LEN_EXTRA;
  localparam int QB = W - 1;

  logic [NW-1:0] num;
  logic [EW-1:0] rem_q [QB];
  logic [QB-1:0] lo_q  [QB];
  logic [QB-1:0] q_q   [QB];
  logic [EW-1:0] d_q   [QB];
  logic          n_q   [QB];

  assign num = {prod, {LEN_EXTRA{1'b0}}};

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [EW-1:0] rem_i;
    logic [QB-1:0] lo_i;
    logic [QB-1:0] q_i;
    logic [EW-1:0] d_i;
    logic          n_i;
    logic [EW:0]   rs;
    logic [EW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i = EW'(num[NW-1:QB]);
      assign lo_i  = num[QB-1:0];
      assign q_i   = '0;
      assign d_i   = dvs;
      assign n_i   = neg;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign lo_i  = lo_q[k-1];
      assign q_i   = q_q[k-1];
      assign d_i   = d_q[k-1];
      assign n_i   = n_q[k-1];
    end

    // shift in the next numerator bit and subtract when it fits
    assign rs   = {rem_i, lo_i[QB-1]};
    assign diff = rs - {1'b0, d_i};
    assign ge   = (rs >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k] <= ge ? diff[EW-1:0] : rs[EW-1:0];
        lo_q[k]  <= lo_i << 1;
        q_q[k]   <= {q_i[QB-2:0], ge};
        d_q[k]   <= d_i;
        n_q[k]   <= n_i;
      end
    end
  end

  // apply the sign; the quotient never exceeds the wanted length
  always_ff @(posedge clk) begin
    if (ce) begin
      dir <= n_q[QB-1] ? -$signed({1'b0, q_q[QB-1]}) : $signed({1'b0, q_q[QB-1]});
    end
  end

endmodule

// ----- hw/rtl/direction_vector_to_length_top.sv -----
// top level of the 3d direction vector normalization pipeline
//
// Usage: each input word on item_in carries a base point, a target point and a
// wanted length, all fixed point with 16 fraction bits by default. Each word
// gives exactly one output word on result_out: the vector from base to target
// scaled to the wanted length, truncated toward zero. When base equals target
// zero_length is set and the components are zero.
// Pipeline: the lane registers for difference and squares, the merge register,
// W + 16 square root stages (one root bit each), W - 1 divider stages (one
// quotient bit each), the sign register and the output register. Throughput:
// one word per cycle while the receiver does not stall.
// The whole pipeline advances together; item_in.ready is high whenever the
// output register is empty or being taken. When the receiver stalls with a
// word waiting, the pipeline holds and item_in.ready drops.
// Reset clears the valid track only; no word is in flight afterwards.
module direction_vector_to_length_top import nvec_pkg::*; #(
  parameter int W = 32
) (
  input  logic       clk,
  input  logic       rst,
  nvec_in_if.sink    item_in,
  nvec_out_if.source result_out
);

  localparam int EW  = W + 2 + LEN_EXTRA;
  localparam int QB  = W - 1;
  localparam int SQL = EW + 1;
  localparam int LAT = EW + QB + 5;

  logic                ce;
  logic [LAT-1:0]      vpipe;
  logic signed [W-1:0] base   [NUM_LANES];
  logic signed [W-1:0] target [NUM_LANES];
  logic [2*W+1:0]      sq     [NUM_LANES];
  logic [2*W-1:0]      prod   [NUM_LANES];
  logic                neg    [NUM_LANES];
  logic [2*W:0]        side_q [NUM_LANES][SQL];
  logic signed [W-1:0] dir    [NUM_LANES];
  logic [EW-1:0]       root;
  logic                zero_s;
  logic [QB:0]         zpipe;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;
  logic                zero_length;

  // global advance: output empty or being taken
  assign ce            = !vpipe[LAT-1] || result_out.ready;
  assign item_in.ready = ce;

  assign base[0]   = item_in.base_x;
  assign base[1]   = item_in.base_y;
  assign base[2]   = item_in.base_z;
  assign target[0] = item_in.target_x;
  assign target[1] = item_in.target_y;
  assign target[2] = item_in.target_z;

  // valid track
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ce) begin
      vpipe <= {vpipe[LAT-2:0], item_in.valid};
    end
  end

  // per-component lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    nvec_lane #(.W(W)) u_lane (
      .clk    (clk),
      .ce     (ce),
      .base   (base[l]),
      .target (target[l]),
      .len    (item_in.scale_length),
      .sq     (sq[l]),
      .prod   (prod[l]),
      .neg    (neg[l])
    );

    // hold numerator and sign while the length is found
    always_ff @(posedge clk) begin
      if (ce) begin
        side_q[l][0] <= {prod[l], neg[l]};
        for (int s = 1; s < SQL; s++) begin
          side_q[l][s] <= side_q[l][s-1];
        end
      end
    end

    nvec_div #(.W(W)) u_div (
      .clk  (clk),
      .ce   (ce),
      .prod (side_q[l][SQL-1][2*W:1]),
      .dvs  (root),
      .neg  (side_q[l][SQL-1][0]),
      .dir  (dir[l])
    );
  end

  // merge of the lanes into the vector length
  nvec_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .sq0  (sq[0]),
    .sq1  (sq[1]),
    .sq2  (sq[2]),
    .root (root),
    .zero (zero_s)
  );

  // zero flag follows the divider
  always_ff @(posedge clk) begin
    if (ce) begin
      zpipe <= {zpipe[QB-1:0], zero_s};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ce) begin
      zero_length <= zpipe[QB];
      dir_x       <= zpipe[QB] ? '0 : dir[0];
      dir_y       <= zpipe[QB] ? '0 : dir[1];
      dir_z       <= zpipe[QB] ? '0 : dir[2];
    end
  end

  assign result_out.valid       = vpipe[LAT-1];
  assign result_out.dir_x       = dir_x;
  assign result_out.dir_y       = dir_y;
  assign result_out.dir_z       = dir_z;
  assign result_out.zero_length = zero_length;

endmodule

// ----- hw/rtl/nvec_checker.sv -----
// port level checks for the normalization block, bound to the top level
module nvec_checker #(
  parameter int W = 32
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] dir_x,
  input logic signed [W-1:0] dir_y,
  input logic signed [W-1:0] dir_z,
  input logic                zero_length
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(dir_y)
      && $stable(dir_z) && $stable(zero_length))
    else $error("stalled output word changed");

  // zero length gives zero components
  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> dir_x == '0 && dir_y == '0 && dir_z == '0)
    else $error("zero length with nonzero components");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // input is never taken while a waiting word is stuck
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input taken during output stall");

endmodule

bind direction_vector_to_length_top nvec_checker #(.W(W)) u_nvec_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item_in.valid),
  .in_ready    (item_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .dir_x       (result_out.dir_x),
  .dir_y       (result_out.dir_y),
  .dir_z       (result_out.dir_z),
  .zero_length (result_out.zero_length)
);

// ----- tb/sv/tb.sv -----
// self-checking testbench for the 3d direction vector normalization block
`timescale 1ns / 100ps

module tb import nvec_pkg::*;;

  localparam int W = 32;

  typedef struct {
    logic signed [W-1:0] bx, by, bz;
    logic signed [W-1:0] tx, ty, tz;
    logic [W-2:0]        len;
  } point_pair_t;

  typedef struct {
    logic signed [W-1:0] dx, dy, dz;
    logic                zero;
  } direction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nvec_in_if  #(.W(W)) item_if ();
  nvec_out_if #(.W(W)) result_if ();

  direction_vector_to_length_top #(.W(W)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if)
  );

  always #5 clk = ~clk;

  direction_t dir_queue[$];
  int errors      = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int zero_seen   = 0;
  bit calm        = 1'b0;

  // scaled direction from base to target, truncated toward zero
  function automatic direction_t scale_direction(point_pair_t p);
    logic signed [W:0] d[3];
    logic [127:0] mag[3];
    logic [127:0] sum, root, cand, q, maxpos;
    direction_t r;
    d[0] = $signed({p.tx[W-1], p.tx}) - $signed({p.bx[W-1], p.bx});
    d[1] = $signed({p.ty[W-1], p.ty}) - $signed({p.by[W-1], p.by});
    d[2] = $signed({p.tz[W-1], p.tz}) - $signed({p.bz[W-1], p.bz});
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = '0;
      mag[i][W:0] = d[i][W] ? -d[i] : d[i];
      sum = sum + mag[i] * mag[i];
    end
    r.dx = '0; r.dy = '0; r.dz = '0;
    r.zero = (sum == 0);
    if (r.zero) return r;
    // bitwise integer square root of the widened sum
    sum = sum << (2 * LEN_EXTRA);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sum) root = cand;
    end
    maxpos = (128'd1 << (W - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] * {97'd0, p.len}) << LEN_EXTRA) / root;
      if (d[i][W]) begin
        if (q > maxpos + 1) q = maxpos + 1;
        q = -q;
      end else if (q > maxpos) q = maxpos;
      if (i == 0) r.dx = q[W-1:0];
      else if (i == 1) r.dy = q[W-1:0];
      else r.dz = q[W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
    errors++;
  endtask

  // random gap length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls and word checking
  int stall_left = 0;
  always @(posedge clk) begin
    direction_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (dir_queue.size() == 0) begin
          $display("unexpected result word %0d", words_seen);
          errors++;
        end else begin
          want = dir_queue.pop_front();
          if (result_if.dir_x !== want.dx) report_mismatch("dir_x", result_if.dir_x, want.dx);
          if (result_if.dir_y !== want.dy) report_mismatch("dir_y", result_if.dir_y, want.dy);
          if (result_if.dir_z !== want.dz) report_mismatch("dir_z", result_if.dir_z, want.dz);
          if (result_if.zero_length !== want.zero)
            report_mismatch("zero_length", {{(W-1){1'b0}}, result_if.zero_length},
                            {{(W-1){1'b0}}, want.zero});
          if (want.zero) zero_seen++;
        end
        words_seen++;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        result_if.ready <= 1'b1;
      end
    end
  end

  // send one word and wait until it is taken
  task automatic send_word(point_pair_t p);
    int gap;
    item_if.valid        <= 1'b1;
    item_if.base_x       <= p.bx;
    item_if.base_y       <= p.by;
    item_if.base_z       <= p.bz;
    item_if.target_x     <= p.tx;
    item_if.target_y     <= p.ty;
    item_if.target_z     <= p.tz;
    item_if.scale_length <= p.len;
    do @(posedge clk); while (!item_if.ready);
    dir_queue.push_back(scale_direction(p));
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected word has come back
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (dir_queue.size() != 0) @(posedge clk);
  endtask

  function automatic point_pair_t make_pair(logic [W-1:0] bx, by, bz, tx, ty, tz,
                                            logic [W-2:0] len);
    point_pair_t p;
    p.bx = bx; p.by = by; p.bz = bz; p.tx = tx; p.ty = ty; p.tz = tz; p.len = len;
    return p;
  endfunction

  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-2:0] LMAX = '1;
  localparam logic [W-2:0] ONE  = 31'h1_0000;

  // extremes of the coordinate range, zero length and zero wanted length
  task automatic test_directed();
    send_word(make_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, LMAX));
    send_word(make_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, LMAX));
    send_word(make_pair(CMAX, CMIN, 0, CMIN, CMAX, 0, ONE));
    send_word(make_pair(CMIN, 0, CMAX, CMAX, 0, CMIN, 31'd1));
    send_word(make_pair(0, 0, 0, 0, 0, 0, ONE));
    send_word(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, LMAX));
    send_word(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 31'd0));
    send_word(make_pair(0, 0, 0, 32'd5, 32'hffff_fff0, 32'd7, 31'd0));
    send_word(make_pair(0, 0, 0, 32'd1, 0, 0, LMAX));
    send_word(make_pair(0, 0, 0, 0, 32'hffff_ffff, 0, LMAX));
    send_word(make_pair(0, 0, 0, 0, 0, CMIN, ONE));
    send_word(make_pair(0, 0, 0, 0, 0, CMAX, ONE));
    send_word(make_pair(0, 0, 0, 32'd1, 32'd1, 32'd1, LMAX));
    send_word(make_pair(32'd3, 32'd4, 0, 0, 0, 0, 31'd5 << 16));
    send_word(make_pair(32'h1234_5678, 0, 32'hffff_0000, 32'h1234_5679, 0, 32'hffff_0000,
                        31'd1));
    send_word(make_pair(CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 31'h5555_5555));
    send_word(make_pair(0, 0, 0, 32'hffff_fffe, 32'd3, 32'hffff_fffd, 31'h2aaa_aaaa));
  endtask

  // random geometry: full range, nearby points, equal points
  task automatic test_random(int count);
    point_pair_t p;
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) calm = ~calm;
      kind = $urandom_range(0, 99);
      p.bx = $urandom(); p.by = $urandom(); p.bz = $urandom();
      if (kind < 40) begin
        p.tx = $urandom(); p.ty = $urandom(); p.tz = $urandom();
      end else if (kind < 90) begin
        p.tx = p.bx + $signed(32'($urandom_range(0, 2000)) - 1000);
        p.ty = p.by + $signed(32'($urandom_range(0, 2000)) - 1000);
        p.tz = p.bz + $signed(32'($urandom_range(0, 2000)) - 1000);
      end else begin
        p.tx = p.bx; p.ty = p.by; p.tz = p.bz;
      end
      case ($urandom_range(0, 3))
        0: p.len = 31'($urandom());
        1: p.len = 31'($urandom_range(0, 32'h4_0000));
        2: p.len = LMAX - 31'($urandom_range(0, 15));
        default: p.len = 31'($urandom_range(0, 3)) << $urandom_range(0, 29);
      endcase
      send_word(p);
    end
    calm = 1'b0;
  endtask

  // sender holds off until the pipeline has emptied
  task automatic test_drain_pause();
    wait_drained();
    send_word(make_pair(0, 0, 0, 32'd100, 32'hffff_ff00, 32'd7, ONE));
    send_word(make_pair(32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, ONE));
  endtask

  initial begin
    item_if.valid        = 1'b0;
    item_if.base_x       = '0;
    item_if.base_y       = '0;
    item_if.base_z       = '0;
    item_if.target_x     = '0;
    item_if.target_y     = '0;
    item_if.target_z     = '0;
    item_if.scale_length = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(630);
    wait_drained();
    repeat (120) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d with zero length",
             words_sent, words_seen, zero_seen);
    $display("covered range extremes, zero wanted length, nearby and random points");
    if (errors == 0 && dir_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", dir_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- direction_vector_to_length_top.f -----
hw/rtl/nvec_pkg.sv
hw/rtl/nvec_in_if.sv
hw/rtl/nvec_out_if.sv
hw/rtl/nvec_lane.sv
hw/rtl/nvec_sqrt.sv
hw/rtl/nvec_div.sv
hw/rtl/direction_vector_to_length_top.sv
hw/rtl/nvec_checker.sv
tb/sv/tb.sv
